// ===== rtl/prc_pkg.sv =====
// Shared types, text tables and constants of the prompt response classifier.
`default_nettype none

package prc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_SUCCESS     = 3'd0,
    STATUS_SEARCHING   = 3'd1,
    STATUS_NO_DATA     = 3'd2,
    STATUS_BUS_INIT    = 3'd3,
    STATUS_UNABLE      = 3'd4,
    STATUS_STOPPED     = 3'd5,
    STATUS_UNSUPPORTED = 3'd6
  } status_t;

  // Byte classes handed from the front to the back
  typedef enum logic [2:0] {
    TOK_CLEAR    = 3'd0,
    TOK_PROMPT   = 3'd1,
    TOK_EOL      = 3'd2,
    TOK_SPACE    = 3'd3,
    TOK_OTHER_WS = 3'd4,
    TOK_CHAR     = 3'd5
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;     // upper-case folded character, valid for TOK_CHAR
  } tok_t;

  localparam int unsigned TEXT_COUNT     = 6;
  localparam int unsigned TIDX_W         = 3;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned MAX_TEXT_BYTES = 17;
  localparam logic [TIDX_W-1:0] SEARCH_IDX = TIDX_W'(5);

  // Each text is right-aligned: its last character sits in byte 0
  localparam logic [TEXT_COUNT-1:0][MAX_TEXT_BYTES-1:0][7:0] TEXT_ROM = '{
    5: "SEARCHING...",
    4: "?",
    3: "STOPPED",
    2: "UNABLE TO CONNECT",
    1: "BUS INIT: ERROR",
    0: "NO DATA"
  };

  localparam logic [POS_W-1:0] TEXT_LEN [TEXT_COUNT] = '{
    5'd7, 5'd15, 5'd17, 5'd7, 5'd1, 5'd12
  };

  localparam status_t TEXT_STATUS [TEXT_COUNT] = '{
    STATUS_NO_DATA, STATUS_BUS_INIT, STATUS_UNABLE,
    STATUS_STOPPED, STATUS_UNSUPPORTED, STATUS_SEARCHING
  };

  localparam int unsigned MAX_LINE_COUNT = 255;
  localparam logic [7:0]  COUNT_CAP =
    (MAX_LINE_COUNT > 255) ? 8'd255 : 8'(MAX_LINE_COUNT);

  // Token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

endpackage

`default_nettype wire

// ===== rtl/prc_front.sv =====
// Front end: classifies each accepted request into a token.
`default_nettype none

module prc_front (
  input  wire logic         action,
  input  wire logic [7:0]   byte_value,
  output prc_pkg::tok_t     tok
);

  always_comb begin
    tok.ch   = byte_value;
    tok.kind = prc_pkg::TOK_CHAR;
    if (action) begin
      tok.kind = prc_pkg::TOK_CLEAR;
    end else if (byte_value == prc_pkg::CH_PROMPT) begin
      tok.kind = prc_pkg::TOK_PROMPT;
    end else if (byte_value == prc_pkg::CH_CR || byte_value == prc_pkg::CH_LF) begin
      tok.kind = prc_pkg::TOK_EOL;
    end else if (byte_value == prc_pkg::CH_SPACE) begin
      tok.kind = prc_pkg::TOK_SPACE;
    end else if (byte_value == prc_pkg::CH_TAB || byte_value == prc_pkg::CH_VT ||
                 byte_value == prc_pkg::CH_FF) begin
      tok.kind = prc_pkg::TOK_OTHER_WS;
    end else if (byte_value >= 8'h61 && byte_value <= 8'h7A) begin
      // fold a-z to upper case
      tok.ch = byte_value - 8'h20;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prc_queue.sv =====
// Short token queue decoupling the front end from the matcher back end.
`default_nettype none

module prc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire prc_pkg::tok_t push_tok,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output prc_pkg::tok_t      head_tok
);

  prc_pkg::tok_t mem [prc_pkg::QUEUE_DEPTH];

  logic [prc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [prc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [prc_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                       do_push, do_pop;

  assign full       = (count_r == (prc_pkg::QPTR_W+1)'(prc_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prc_back.sv =====
// Back end: incremental text matchers, line bookkeeping and result register.
`default_nettype none

module prc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire prc_pkg::tok_t head_tok,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_status,
  output logic [7:0]         out_line_count
);

  localparam int unsigned TC = prc_pkg::TEXT_COUNT;

  logic [prc_pkg::POS_W-1:0] pos_r [TC];
  logic [prc_pkg::POS_W-1:0] pos_nxt [TC];
  logic [TC-1:0]             fail_r, fail_nxt;
  logic                      has_text_r, has_text_nxt;
  logic [1:0]                gap_r, gap_nxt;
  prc_pkg::status_t          first_err_r, first_err_nxt;
  logic                      search_r, search_nxt;
  logic [7:0]                lines_r, lines_nxt;
  logic                      out_valid_r, out_valid_nxt;
  prc_pkg::status_t          out_status_r, out_status_nxt;
  logic [7:0]                out_count_r, out_count_nxt;

  prc_pkg::status_t          el_first;
  logic                      el_search;
  logic [7:0]                el_lines;
  logic                      slot_free;

  // One matcher step: returns {fail, position}
  function automatic logic [prc_pkg::POS_W:0] feed(
    input logic [prc_pkg::TIDX_W-1:0] k,
    input logic [prc_pkg::POS_W-1:0]  pos,
    input logic                       fail,
    input logic [7:0]                 c
  );
    logic [prc_pkg::POS_W-1:0] bi;
    logic [prc_pkg::POS_W:0]   res;
    bi  = prc_pkg::TEXT_LEN[k] - 5'd1 - pos;
    res = {fail, pos};
    if (!fail) begin
      if (pos < prc_pkg::TEXT_LEN[k] && prc_pkg::TEXT_ROM[k][bi] == c) begin
        res = {1'b0, pos + 5'd1};
      end else begin
        res = {1'b1, pos};
      end
    end
    return res;
  endfunction

  assign slot_free      = !out_valid_r || !out_stall;
  assign pop            = head_valid && (head_tok.kind != prc_pkg::TOK_PROMPT || slot_free);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_line_count = out_count_r;

  // Response state as it stands once the current line is closed
  always_comb begin
    el_first  = first_err_r;
    el_search = search_r;
    el_lines  = lines_r;
    if (has_text_r) begin
      if (lines_r < prc_pkg::COUNT_CAP) begin
        el_lines = lines_r + 8'd1;
      end
      for (int k = 0; k < TC; k++) begin
        if (!fail_r[k] && pos_r[k] == prc_pkg::TEXT_LEN[k]) begin
          if (prc_pkg::TIDX_W'(k) == prc_pkg::SEARCH_IDX) begin
            el_search = 1'b1;
          end else if (el_first == prc_pkg::STATUS_SUCCESS) begin
            el_first = prc_pkg::TEXT_STATUS[k];
          end
        end
      end
    end
  end

  always_comb begin
    logic [prc_pkg::POS_W:0] step;
    pos_nxt        = pos_r;
    fail_nxt       = fail_r;
    has_text_nxt   = has_text_r;
    gap_nxt        = gap_r;
    first_err_nxt  = first_err_r;
    search_nxt     = search_r;
    lines_nxt      = lines_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    step           = '0;

    if (pop) begin
      unique case (head_tok.kind)
        prc_pkg::TOK_CLEAR, prc_pkg::TOK_EOL, prc_pkg::TOK_PROMPT: begin
          for (int k = 0; k < TC; k++) begin
            pos_nxt[k] = '0;
          end
          fail_nxt     = '0;
          has_text_nxt = 1'b0;
          gap_nxt      = 2'd0;
          if (head_tok.kind == prc_pkg::TOK_EOL) begin
            first_err_nxt = el_first;
            search_nxt    = el_search;
            lines_nxt     = el_lines;
          end else begin
            first_err_nxt = prc_pkg::STATUS_SUCCESS;
            search_nxt    = 1'b0;
            lines_nxt     = '0;
          end
          if (head_tok.kind == prc_pkg::TOK_PROMPT) begin
            out_valid_nxt  = 1'b1;
            out_count_nxt  = el_lines;
            if (el_first != prc_pkg::STATUS_SUCCESS) begin
              out_status_nxt = el_first;
            end else if (el_search) begin
              out_status_nxt = prc_pkg::STATUS_SEARCHING;
            end else begin
              out_status_nxt = prc_pkg::STATUS_SUCCESS;
            end
          end
        end
        prc_pkg::TOK_SPACE, prc_pkg::TOK_OTHER_WS: begin
          if (has_text_r) begin
            gap_nxt = (gap_r == 2'd0 && head_tok.kind == prc_pkg::TOK_SPACE) ? 2'd1 : 2'd2;
          end
        end
        prc_pkg::TOK_CHAR: begin
          for (int k = 0; k < TC; k++) begin
            step = {fail_r[k], pos_r[k]};
            if (gap_r == 2'd1) begin
              step = feed(prc_pkg::TIDX_W'(k), step[prc_pkg::POS_W-1:0],
                          step[prc_pkg::POS_W], prc_pkg::CH_SPACE);
            end else if (gap_r == 2'd2) begin
              step[prc_pkg::POS_W] = 1'b1;
            end
            step = feed(prc_pkg::TIDX_W'(k), step[prc_pkg::POS_W-1:0],
                        step[prc_pkg::POS_W], head_tok.ch);
            fail_nxt[k] = step[prc_pkg::POS_W];
            pos_nxt[k]  = step[prc_pkg::POS_W-1:0];
          end
          gap_nxt      = 2'd0;
          has_text_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TC; k++) begin
        pos_r[k] <= '0;
      end
      fail_r      <= '0;
      has_text_r  <= 1'b0;
      gap_r       <= 2'd0;
      first_err_r <= prc_pkg::STATUS_SUCCESS;
      search_r    <= 1'b0;
      lines_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fail_r      <= fail_nxt;
      has_text_r  <= has_text_nxt;
      gap_r       <= gap_nxt;
      first_err_r <= first_err_nxt;
      search_r    <= search_nxt;
      lines_r     <= lines_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/prompt_response_classifier_core.sv =====
// Top level of the prompt response classifier: front end, token queue and back end.
// Throughput: one request per cycle while the queue has room; the matcher back end retires one
// token a cycle unless a prompt waits for a free result slot; results leave from a register.
// The four-entry token queue absorbs stalls on the result side; input stalls only when it fills.
// Reset: rst_n is synchronous and active low; it empties the queue, clears all line and
// response state and drops any pending result.
`default_nettype none

module prompt_response_classifier_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [7:0] in_byte_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_line_count
);

  prc_pkg::tok_t front_tok;   // classified request from the front end
  prc_pkg::tok_t head_tok;    // oldest queued token, seen by the back end
  logic          q_full;
  logic          head_valid;
  logic          pop;

  // Classify each byte: clear, prompt, end of line, whitespace or folded character
  prc_front u_front (
    .action     (in_action),
    .byte_value (in_byte_value),
    .tok        (front_tok)
  );

  // Hold off new requests only while the queue is full
  assign in_stall = q_full;

  prc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_tok   (front_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // Advance matchers one token a cycle; a prompt waits only for a free result slot
  prc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_tok       (head_tok),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_line_count (out_line_count)
  );

endmodule

`default_nettype wire

// ===== rtl/prc_checker.sv =====
// Port-level checker for the classifier core, with its bind statement.
`default_nettype none

module prc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_line_count
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_line_count))
    else $error("stalled result changed");

  // Only defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= prc_pkg::STATUS_UNSUPPORTED)
    else $error("undefined status code");

  // Any status other than success comes from a counted line
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != prc_pkg::STATUS_SUCCESS |-> out_line_count != 8'd0)
    else $error("classified status with zero lines");

  // Reset drops any result and empties the queue
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left state behind");

endmodule

bind prompt_response_classifier_core prc_checker u_prc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_line_count (out_line_count)
);

`default_nettype wire
